/* src/lwd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LCD window draw package
// Shared types, codes and constants of the window draw command generator.
// ----------------------------------------------------------------------------
package lwd_pkg;

  localparam int COORD_W = 10;
  localparam int COLOUR_W = 16;
  localparam int COUNT_W = 17;
  localparam int BYTE_W = 8;
  localparam int STEP_W = 4;

  localparam int PANEL_SHORT_DEF = 240;
  localparam int PANEL_LONG_DEF = 320;

  // The queue depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_RECT = 3'd3;
  localparam logic [2:0] OP_FILL = 3'd4;
  localparam logic [2:0] OP_ROTATE = 3'd5;

  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_PARAM = 2'd1;
  localparam logic [1:0] KIND_RUN = 2'd2;

  localparam logic [BYTE_W-1:0] CMD_CASET = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_RASET = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_RAMWR = 8'h2C;
  localparam logic [BYTE_W-1:0] CMD_MADCTL = 8'h36;

  localparam logic [STEP_W-1:0] STEP_ROT_END = 4'd1;
  localparam logic [STEP_W-1:0] STEP_WIN_END = 4'd11;

  typedef struct packed {
    logic [2:0]          op;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [COORD_W-1:0]  size_w;
    logic [COORD_W-1:0]  size_h;
    logic [COLOUR_W-1:0] colour;
    logic [1:0]          rotation;
  } req_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [BYTE_W-1:0]   byte_value;
    logic [COLOUR_W-1:0] run_colour;
    logic [COUNT_W-1:0]  run_count;
    logic                last;
  } res_t;

  typedef struct packed {
    logic                is_rot;
    logic [BYTE_W-1:0]   mode;
    logic [COORD_W-1:0]  x1;
    logic [COORD_W-1:0]  x2;
    logic [COORD_W-1:0]  y1;
    logic [COORD_W-1:0]  y2;
    logic [COORD_W-1:0]  w;
    logic [COORD_W-1:0]  h;
    logic [COLOUR_W-1:0] colour;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [BYTE_W-1:0] mode_byte(input logic [1:0] rot);
    logic [BYTE_W-1:0] m;
    unique case (rot)
      2'd0: m = 8'h40 | 8'h08;
      2'd1: m = 8'h20 | 8'h08;
      2'd2: m = 8'h80 | 8'h08;
      default: m = 8'h40 | 8'h80 | 8'h20 | 8'h08;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* src/lcd_window_draw_command_generator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LCD window draw command generator
// Clips draw requests to the panel and emits the window, memory write and
// colour run command stream, or the orientation command for a rotation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  lwd_pkg::req_t
// res       out        res_valid/res_stall  lwd_pkg::res_t
//
// A drawing request yields twelve results, a rotation two; the back end's
// step counter sets this, and a queued request follows without a gap.
// A request passes through the job queue and job register to the output.
// The job queue holds two requests; req_stall is high while it is full.
// Reset clears the orientation to portrait, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module lcd_window_draw_command_generator_unit #(
  parameter int PANEL_SHORT = lwd_pkg::PANEL_SHORT_DEF,
  parameter int PANEL_LONG = lwd_pkg::PANEL_LONG_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire lwd_pkg::req_t  req,
  output logic                res_valid,
  input  wire logic           res_stall,
  output lwd_pkg::res_t       res
);

  logic             accept;
  logic             push;
  logic             pop;
  lwd_pkg::entry_t  wr_entry;
  lwd_pkg::entry_t  head;
  lwd_pkg::q_stat_t q_stat;

  assign req_stall = q_stat.full;
  assign accept = req_valid && !req_stall;

  lwd_front #(
    .PANEL_SHORT(PANEL_SHORT),
    .PANEL_LONG(PANEL_LONG)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .req(req),
    .push(push),
    .entry(wr_entry)
  );

  lwd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_entry(wr_entry),
    .pop(pop),
    .head(head),
    .stat(q_stat)
  );

  lwd_back u_back (
    .clk(clk),
    .rst(rst),
    .q_stat(q_stat),
    .head(head),
    .pop(pop),
    .res_stall(res_stall),
    .res_valid(res_valid),
    .res(res)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("Item pushed into a full job queue.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("Item popped from an empty job queue.");

  a_run_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == lwd_pkg::KIND_RUN) |-> res.last)
    else $error("Colour run item is not the last item of its request.");

  a_madctl_param_follows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && res.kind == lwd_pkg::KIND_CMD &&
     res.byte_value == lwd_pkg::CMD_MADCTL)
    |=> (res_valid && res.kind == lwd_pkg::KIND_PARAM && res.last))
    else $error("Orientation command not followed by its mode byte.");

endmodule
`default_nettype wire

/* src/lwd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LCD window draw front end
// Classifies each request, clips it to the panel and queues a window or rotation job.
// ----------------------------------------------------------------------------
module lwd_front #(
  parameter int PANEL_SHORT = lwd_pkg::PANEL_SHORT_DEF,
  parameter int PANEL_LONG = lwd_pkg::PANEL_LONG_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire lwd_pkg::req_t  req,
  output logic                push,
  output lwd_pkg::entry_t     entry
);

  localparam int CW = lwd_pkg::COORD_W;
  localparam logic [CW-1:0] PS = CW'(PANEL_SHORT);
  localparam logic [CW-1:0] PL = CW'(PANEL_LONG);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [1:0]    orientation;
  logic [CW-1:0] pw;
  logic [CW-1:0] ph;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] h_eff;
  logic [CW:0]   x_end;
  logic [CW:0]   y_end;
  logic [CW-1:0] x2;
  logic [CW-1:0] y2;
  logic          on_screen;
  logic          emit;

  assign pw = orientation[0] ? PL : PS;
  assign ph = orientation[0] ? PS : PL;

  always_comb begin
    w_eff = req.size_w;
    h_eff = req.size_h;
    unique case (req.op)
      lwd_pkg::OP_PIXEL: begin
        w_eff = ONE;
        h_eff = ONE;
      end
      lwd_pkg::OP_HLINE: h_eff = ONE;
      lwd_pkg::OP_VLINE: w_eff = ONE;
      default: ;
    endcase
  end

  assign x_end = {1'b0, req.pos_x} + {1'b0, w_eff} - {1'b0, ONE};
  assign y_end = {1'b0, req.pos_y} + {1'b0, h_eff} - {1'b0, ONE};
  assign x2 = (x_end >= {1'b0, pw}) ? pw - ONE : x_end[CW-1:0];
  assign y2 = (y_end >= {1'b0, ph}) ? ph - ONE : y_end[CW-1:0];
  assign on_screen = (req.pos_x < pw) && (req.pos_y < ph) &&
                     (w_eff != '0) && (h_eff != '0);

  always_comb begin
    entry.is_rot = 1'b0;
    entry.mode = lwd_pkg::mode_byte(req.rotation);
    entry.x1 = req.pos_x;
    entry.y1 = req.pos_y;
    entry.x2 = x2;
    entry.y2 = y2;
    entry.w = x2 - req.pos_x + ONE;
    entry.h = y2 - req.pos_y + ONE;
    entry.colour = req.colour;
    emit = 1'b0;
    unique case (req.op) inside
      lwd_pkg::OP_ROTATE: begin
        entry.is_rot = 1'b1;
        emit = 1'b1;
      end
      lwd_pkg::OP_FILL: begin
        entry.x1 = '0;
        entry.y1 = '0;
        entry.x2 = pw - ONE;
        entry.y2 = ph - ONE;
        entry.w = pw;
        entry.h = ph;
        emit = 1'b1;
      end
      lwd_pkg::OP_PIXEL, lwd_pkg::OP_HLINE, lwd_pkg::OP_VLINE, lwd_pkg::OP_RECT:
        emit = on_screen;
      default: emit = 1'b0;
    endcase
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= 2'd0;
    end else if (accept && req.op == lwd_pkg::OP_ROTATE) begin
      orientation <= req.rotation;
    end
  end

endmodule
`default_nettype wire

/* src/lwd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LCD window draw job queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module lwd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lwd_pkg::entry_t  wr_entry,
  input  wire logic             pop,
  output lwd_pkg::entry_t       head,
  output lwd_pkg::q_stat_t      stat
);

  localparam int DEPTH = lwd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lwd_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head = slots[rd_ptr];
  assign stat.full = (fill == CNT_W'(DEPTH));
  assign stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* src/lwd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LCD window draw back end
// Steps through the command bytes of one queued job into the output register.
// ----------------------------------------------------------------------------
module lwd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lwd_pkg::q_stat_t  q_stat,
  input  wire lwd_pkg::entry_t   head,
  output logic                   pop,
  input  wire logic              res_stall,
  output logic                   res_valid,
  output lwd_pkg::res_t          res
);

  localparam int SW = lwd_pkg::STEP_W;
  localparam int CW = lwd_pkg::COORD_W;
  localparam int PW = 2 * CW;

  logic            busy;
  logic [SW-1:0]   step;
  lwd_pkg::entry_t cur;
  logic [lwd_pkg::COUNT_W-1:0] count;
  logic [PW-1:0]   prod;
  logic            adv;
  logic            at_end;
  lwd_pkg::res_t   item;

  assign prod = head.w * head.h;
  assign adv = !res_valid || !res_stall;
  assign at_end = (step == (cur.is_rot ? lwd_pkg::STEP_ROT_END : lwd_pkg::STEP_WIN_END));
  assign pop = !q_stat.empty && (!busy || (adv && at_end));

  always_comb begin
    item = '0;
    item.last = at_end;
    item.kind = lwd_pkg::KIND_PARAM;
    if (cur.is_rot) begin
      if (step == '0) begin
        item.kind = lwd_pkg::KIND_CMD;
        item.byte_value = lwd_pkg::CMD_MADCTL;
      end else begin
        item.byte_value = cur.mode;
      end
    end else begin
      unique case (step)
        4'd0: begin
          item.kind = lwd_pkg::KIND_CMD;
          item.byte_value = lwd_pkg::CMD_CASET;
        end
        4'd1: item.byte_value = 8'(cur.x1[CW-1:8]);
        4'd2: item.byte_value = cur.x1[7:0];
        4'd3: item.byte_value = 8'(cur.x2[CW-1:8]);
        4'd4: item.byte_value = cur.x2[7:0];
        4'd5: begin
          item.kind = lwd_pkg::KIND_CMD;
          item.byte_value = lwd_pkg::CMD_RASET;
        end
        4'd6: item.byte_value = 8'(cur.y1[CW-1:8]);
        4'd7: item.byte_value = cur.y1[7:0];
        4'd8: item.byte_value = 8'(cur.y2[CW-1:8]);
        4'd9: item.byte_value = cur.y2[7:0];
        4'd10: begin
          item.kind = lwd_pkg::KIND_CMD;
          item.byte_value = lwd_pkg::CMD_RAMWR;
        end
        default: begin
          item.kind = lwd_pkg::KIND_RUN;
          item.run_colour = cur.colour;
          item.run_count = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        res_valid <= busy;
      end
      if (busy && adv) begin
        step <= step + SW'(1);
        if (at_end) begin
          busy <= 1'b0;
        end
      end
      if (pop) begin
        busy <= 1'b1;
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && adv) begin
      res <= item;
    end
    if (pop) begin
      cur <= head;
      count <= prod[lwd_pkg::COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire
